@@ rtl/core/kpl_pkg.sv @@
// Shared types, codes and constants of the keypad code lock.
`default_nettype none

package kpl_pkg;

  // Default number of characters in one code.
  localparam int CODE_LENGTH_DEF = 4;

  // Configuration register indexes and port widths.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_ADMIN_CODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TRIES  = 1'd1;

  // Register reset values: code "1239", three tries.
  localparam logic [31:0] ADMIN_CODE_RST = 32'h3132_3339;
  localparam logic [2:0]  MAX_TRIES_RST  = 3'd3;

  // Highest failure count the counter holds.
  localparam logic [2:0] FAIL_MAX = 3'd7;

  // Result status codes.
  localparam logic [3:0] ST_IGNORED  = 4'd0;
  localparam logic [3:0] ST_STARTED  = 4'd1;
  localparam logic [3:0] ST_STORED   = 4'd2;
  localparam logic [3:0] ST_ERASED   = 4'd3;
  localparam logic [3:0] ST_NOCHANGE = 4'd4;
  localparam logic [3:0] ST_REJECTED = 4'd5;
  localparam logic [3:0] ST_GRANTED  = 4'd6;
  localparam logic [3:0] ST_DENIED   = 4'd7;
  localparam logic [3:0] ST_LOCKED   = 4'd8;

  // Event kinds.
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Special characters.
  localparam logic [7:0] CHAR_ERASE   = 8'h2A; // '*'
  localparam logic [7:0] CHAR_CONFIRM = 8'h23; // '#'

  // Key matrix, indexed by {row, col}.
  localparam logic [7:0] KEY_MAP [16] = '{
    8'h31, 8'h32, 8'h33, 8'h41,
    8'h34, 8'h35, 8'h36, 8'h42,
    8'h37, 8'h38, 8'h39, 8'h43,
    8'h2A, 8'h30, 8'h23, 8'h44
  };

  typedef struct packed {
    logic       kind;
    logic [1:0] key_row;
    logic [1:0] key_col;
  } item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] key_char;
    logic [2:0] entered_count;
    logic [2:0] tries_left;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/kpl_in_reg.sv @@
// Input register of the keypad code lock: holds one key event until the lock takes it.
`default_nettype none

module kpl_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire kpl_pkg::item_t item,
  input  wire logic           advance,
  output logic                held_valid,
  output kpl_pkg::item_t      held
);

  // Hold the event while it cannot move on.
  assign item_stall = held_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held <= item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kpl_fsm.sv @@
// Lock state machine: session phase, entry buffer, failure count and result decode.
`default_nettype none

module kpl_fsm #(
  parameter int CODE_LENGTH = kpl_pkg::CODE_LENGTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire kpl_pkg::item_t item,
  input  wire logic [31:0]    admin_code,
  input  wire logic [2:0]     max_tries,
  output kpl_pkg::result_t    result
);

  localparam int IDX_W = $clog2(CODE_LENGTH + 1);
  localparam logic [IDX_W-1:0] FULL = IDX_W'(CODE_LENGTH);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ENTRY   = 2'd1,
    PH_CONFIRM = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] entry_index, entry_index_next;
  logic [2:0]       fail_count, fail_count_next;
  logic [7:0]       code_buf [CODE_LENGTH];

  logic [7:0]             ch;
  logic                   store;
  logic [3:0]             status;
  logic [2:0]             tries;
  logic [2:0]             fail_bumped;
  logic [CODE_LENGTH-1:0] pos_ok;
  logic                   match;

  // Compare each stored character with its byte of the code; positions
  // before the last four expect a zero byte.
  for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_cmp
    localparam int POS = CODE_LENGTH - 1 - g;
    if (POS < 4) begin : g_byte
      assign pos_ok[g] = (code_buf[g] == admin_code[8*POS +: 8]);
    end else begin : g_zero
      assign pos_ok[g] = (code_buf[g] == 8'd0);
    end
  end
  assign match = &pos_ok;

  assign fail_bumped = (fail_count < kpl_pkg::FAIL_MAX) ? fail_count + 3'd1 : fail_count;

  always_comb begin
    phase_next       = phase;
    entry_index_next = entry_index;
    fail_count_next  = fail_count;
    status           = kpl_pkg::ST_IGNORED;
    ch               = 8'd0;
    store            = 1'b0;
    if (item.kind == kpl_pkg::KIND_START) begin
      phase_next       = PH_ENTRY;
      entry_index_next = '0;
      fail_count_next  = 3'd0;
      status           = kpl_pkg::ST_STARTED;
    end else begin
      ch = kpl_pkg::KEY_MAP[{item.key_row, item.key_col}];
      if (phase != PH_IDLE) begin
        if (ch == kpl_pkg::CHAR_ERASE) begin
          if (entry_index != '0) begin
            entry_index_next = entry_index - IDX_W'(1);
            status           = kpl_pkg::ST_ERASED;
          end else begin
            status = kpl_pkg::ST_NOCHANGE;
          end
        end else if (phase == PH_ENTRY && ch == kpl_pkg::CHAR_CONFIRM) begin
          entry_index_next = '0;
          status           = kpl_pkg::ST_REJECTED;
        end else if (entry_index < FULL) begin
          store            = 1'b1;
          entry_index_next = entry_index + IDX_W'(1);
          status           = kpl_pkg::ST_STORED;
          if (phase == PH_ENTRY && entry_index_next == FULL) begin
            phase_next = PH_CONFIRM;
          end
        end else if (ch == kpl_pkg::CHAR_CONFIRM) begin
          entry_index_next = '0;
          if (match) begin
            phase_next = PH_IDLE;
            status     = kpl_pkg::ST_GRANTED;
          end else begin
            fail_count_next = fail_bumped;
            if (fail_bumped >= max_tries) begin
              phase_next = PH_IDLE;
              status     = kpl_pkg::ST_LOCKED;
            end else begin
              phase_next = PH_ENTRY;
              status     = kpl_pkg::ST_DENIED;
            end
          end
        end else begin
          status = kpl_pkg::ST_NOCHANGE;
        end
      end
    end
    tries = (max_tries > fail_count_next) ? max_tries - fail_count_next : 3'd0;
  end

  assign result.status        = status;
  assign result.key_char      = ch;
  assign result.entered_count = 3'(entry_index_next);
  assign result.tries_left    = tries;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      entry_index <= '0;
      fail_count  <= 3'd0;
    end else if (advance) begin
      phase       <= phase_next;
      entry_index <= entry_index_next;
      fail_count  <= fail_count_next;
    end
  end

  // Entry buffer: write decode on the current index.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (advance && store && entry_index == IDX_W'(i)) begin
        code_buf[i] <= ch;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kpl_out_reg.sv @@
// Result register of the keypad code lock: holds one result until the receiver takes it.
`default_nettype none

module kpl_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             held_valid,
  input  wire kpl_pkg::result_t next_result,
  output logic                  advance,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output kpl_pkg::result_t      result
);

  logic open;

  // The register takes a new result when empty or when its result transfers.
  assign open    = ~result_valid | ~result_stall;
  assign advance = held_valid & open;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (open) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= next_result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/keypad_pin_lock_top.sv @@
// Top level of the keypad code lock: configuration registers and the two-register pipeline.
//
// Usage:
//   Input channel (item_valid / item_stall / item): one decoded key event per
//   transfer, either a key press given by matrix row and column, or a start
//   event that opens a new session and clears the entry and failure counts.
//   Output channel (result_valid / result_stall / result): exactly one result
//   per event, in order: status, mapped character, characters held and tries
//   left.
//   Configuration (cfg_we / cfg_index / cfg_data): index 0 writes the four-
//   character code (first character in the top byte), index 1 writes the
//   failure limit from cfg_data[2:0]. Write only while no event is in flight.
// Timing:
//   An event waits in the input register, where the lock logic decodes it
//   and updates its state, and then lands in the result register.
//   Throughput is one event per cycle while the result is not stalled.
// Reset (rst, synchronous): both registers empty, no session open, code and
//   limit back to "1239" and 3.
// Stall: a stalled result holds; the input register keeps taking one more
//   event, then item_stall rises until the result transfers.
`default_nettype none

module keypad_pin_lock_top #(
  parameter int CODE_LENGTH = kpl_pkg::CODE_LENGTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire kpl_pkg::item_t                 item,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output kpl_pkg::result_t                    result,
  input  wire logic                           cfg_we,
  input  wire logic [kpl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic             advance;
  logic             held_valid;
  kpl_pkg::item_t   held;
  kpl_pkg::result_t next_result;
  logic [31:0]      admin_code;
  logic [2:0]       max_tries;

  // Configuration registers: decode the index, take the low bits of the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      admin_code <= kpl_pkg::ADMIN_CODE_RST;
      max_tries  <= kpl_pkg::MAX_TRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kpl_pkg::REG_ADMIN_CODE: admin_code <= cfg_data[31:0];
        kpl_pkg::REG_MAX_TRIES:  max_tries  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Hold the incoming event until the lock takes it.
  kpl_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  // Decode the held event and advance the lock state when it moves on.
  kpl_fsm #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (held),
    .admin_code (admin_code),
    .max_tries  (max_tries),
    .result     (next_result)
  );

  // Register the result toward the receiver.
  kpl_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .next_result  (next_result),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ rtl/core/kpl_checker.sv @@
// Port checker of the keypad code lock, bound to the top level.
`default_nettype none

module kpl_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire kpl_pkg::result_t result
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A start clears the count and carries no character.
  a_start: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == kpl_pkg::ST_STARTED |->
      result.key_char == 8'd0 && result.entered_count == 3'd0)
    else $error("start result carries stale entry");

  // Every verdict on a confirmed code leaves the buffer empty.
  a_verdict_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == kpl_pkg::ST_GRANTED ||
                     result.status == kpl_pkg::ST_DENIED ||
                     result.status == kpl_pkg::ST_LOCKED ||
                     result.status == kpl_pkg::ST_REJECTED) |->
      result.entered_count == 3'd0)
    else $error("verdict left characters in the buffer");

  // A lockout always reports no tries left.
  a_locked: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == kpl_pkg::ST_LOCKED |-> result.tries_left == 3'd0)
    else $error("lockout with tries left");

endmodule

bind keypad_pin_lock_top kpl_checker u_kpl_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
